// ===== sv/wnaf_pkg.sv =====
// Shared constants and types for the wNAF scalar recoder.
package wnaf_pkg;

    localparam int SCALAR_CHUNKS = 28;
    localparam int FLUSH_WINDOWS = 2;

    localparam int CHUNK_W = 16;
    localparam int ACC_W   = 34;
    localparam int POW_W   = 9;
    localparam int DIG_W   = 9;
    localparam int WB_W    = 3;
    localparam int CNT_W   = 5;
    localparam int FLUSH_W = 2;
    localparam int SHAMT_W = 5;

    localparam logic [WB_W-1:0] WINDOW_BITS_RESET = 3'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END
    } state_t;

    // Digit formed at the current scan position.
    typedef struct packed {
        logic [DIG_W-1:0]        clear_mask;
        logic [DIG_W-1:0]        span;
        logic                    neg;
        logic signed [DIG_W-1:0] value;
    } digit_info_t;

endpackage

// ===== sv/wnaf_digit.sv =====
// Forms one signed odd digit from the low bits of the shifted accumulator.
module wnaf_digit
    import wnaf_pkg::*;
(
    input  logic [DIG_W-1:0] acc_low,
    input  logic [WB_W-1:0]  window_bits,
    output digit_info_t      info
);

    logic [3:0]       top_idx;
    logic [DIG_W-1:0] span;
    logic [DIG_W-1:0] mask;
    logic [DIG_W-1:0] mag;

    always_comb
    begin
        top_idx = 4'({1'b0, window_bits}) + 4'd1;
        span    = DIG_W'(1) << top_idx;
        mask    = span - DIG_W'(1);
        mag     = acc_low & mask;

        info.clear_mask = mask;
        info.span       = span;
        info.neg        = acc_low[top_idx];
        // The odd digit is negative when the bit above it is set.
        info.value      = info.neg ? $signed(mag - span) : $signed(mag);
    end

endmodule

// ===== sv/wnaf_scalar_recoder_core.sv =====
// Top level of the wNAF scalar recoder: chunk intake, window scan and result register.
//
// The block recodes a scalar that arrives as SCALAR_CHUNKS transactions of 16 bits,
// least significant chunk first, into signed odd digits whose magnitude is below
// 2^(window_bits+1). Each digit leaves as one result transaction carrying its bit
// position (power) and its value, in ascending power order; after the last chunk two
// more windows are flushed and an end transaction follows with is_end set and
// digit_total holding the number of digits sent for the scalar. The first chunk only
// loads the accumulator. Every later chunk is added in, then the scan walks the
// 16-bit window through the accumulator shift register: a digit step per digit, a
// skip step per run of up to four zero bits that still lies below a set bit of the
// window, and a step that closes the window once its remaining bits are clear. The
// last chunk also has two flush windows closed and the end record sent. A new chunk
// is taken only when the scan of the previous one is over, so the scan loop sets the
// rate. A result waiting in the output register with result_stall high holds the
// scan only when the next digit needs that register. The window_bits register is
// written through the cfg channel (always ready); the user must write it only while
// the block is idle, which the block itself does not enforce.
module wnaf_scalar_recoder_core
    import wnaf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [WB_W-1:0]         cfg_data,

    input  logic                    chunk_valid,
    output logic                    chunk_stall,
    input  logic [CHUNK_W-1:0]      chunk,

    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [POW_W-1:0]        power,
    output logic signed [DIG_W-1:0] digit,
    output logic [POW_W-1:0]        digit_total,
    output logic                    is_end
);

    state_t state_reg, state_next;

    logic [WB_W-1:0]    window_bits_reg;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   chunk_cnt_reg, chunk_cnt_next;
    logic [POW_W-1:0]   digit_cnt_reg, digit_cnt_next;
    logic [POW_W-1:0]   bitpos_reg, bitpos_next;
    logic [FLUSH_W-1:0] flush_reg, flush_next;
    logic               last_reg, last_next;

    logic                    result_valid_reg;
    logic [POW_W-1:0]        power_reg;
    logic signed [DIG_W-1:0] digit_reg;
    logic [POW_W-1:0]        total_reg;
    logic                    end_reg;

    digit_info_t dinfo;

    logic                 chunk_take;
    logic                 out_free;
    logic [3:0]           win_pos;
    logic [SHAMT_W-1:0]   win_rest;
    logic [CHUNK_W-1:0]   win_mask;
    logic                 win_zero;
    logic [SHAMT_W-1:0]   tz_run;
    logic                 scalar_last;

    // Actions chosen by the controller for this cycle.
    logic                 do_load;
    logic                 do_close;
    logic                 do_skip;
    logic                 do_digit;
    logic                 do_end;

    wnaf_digit u_digit (
        .acc_low     (acc_reg[DIG_W-1:0]),
        .window_bits (window_bits_reg),
        .info        (dinfo)
    );

    assign cfg_ready    = 1'b1;
    assign chunk_stall  = (state_reg != ST_IDLE);
    assign chunk_take   = chunk_valid && !chunk_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign power        = power_reg;
    assign digit        = digit_reg;
    assign digit_total  = total_reg;
    assign is_end       = end_reg;

    // The accumulator has already been shifted by the scan position, so the bits
    // still inside the current window are its low (16 - position) bits.
    assign win_pos     = bitpos_reg[3:0];
    assign win_rest    = SHAMT_W'(CHUNK_W) - SHAMT_W'(win_pos);
    assign win_mask    = {CHUNK_W{1'b1}} >> win_pos;
    assign win_zero    = (acc_reg[CHUNK_W-1:0] & win_mask) == '0;
    assign scalar_last = (chunk_cnt_reg >= CNT_W'(SCALAR_CHUNKS - 1));

    // Zero run below the next set bit, at most one nibble per cycle. Only used when
    // bit zero is clear and a set bit remains in the window, so the run stays inside it.
    always_comb
    begin
        if (acc_reg[1])
        begin
            tz_run = SHAMT_W'(1);
        end
        else if (acc_reg[2])
        begin
            tz_run = SHAMT_W'(2);
        end
        else if (acc_reg[3])
        begin
            tz_run = SHAMT_W'(3);
        end
        else
        begin
            tz_run = SHAMT_W'(4);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (chunk_take && (chunk_cnt_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (win_zero && (flush_reg == '0))
                begin
                    state_next = last_reg ? ST_END : ST_IDLE;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        do_load  = 1'b0;
        do_close = 1'b0;
        do_skip  = 1'b0;
        do_digit = 1'b0;
        do_end   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                do_load = chunk_take;
            end
            ST_SCAN:
            begin
                if (win_zero)
                begin
                    do_close = 1'b1;
                end
                else if (acc_reg[0])
                begin
                    do_digit = out_free;
                end
                else
                begin
                    do_skip = 1'b1;
                end
            end
            ST_END:
            begin
                do_end = out_free;
            end
            default:
            begin
                do_load = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        acc_next       = acc_reg;
        chunk_cnt_next = chunk_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        bitpos_next    = bitpos_reg;
        flush_next     = flush_reg;
        last_next      = last_reg;

        if (do_load)
        begin
            if (chunk_cnt_reg == '0)
            begin
                // First chunk of a scalar restarts the accumulator, counts and bit position.
                acc_next       = ACC_W'(chunk);
                digit_cnt_next = '0;
                bitpos_next    = '0;
                chunk_cnt_next = CNT_W'(1);
            end
            else
            begin
                acc_next   = acc_reg + {2'b00, chunk, {CHUNK_W{1'b0}}};
                last_next  = scalar_last;
                flush_next = scalar_last ? FLUSH_W'(FLUSH_WINDOWS) : '0;
                chunk_cnt_next = scalar_last ? '0 : chunk_cnt_reg + CNT_W'(1);
            end
        end

        if (do_close)
        begin
            acc_next    = acc_reg >> win_rest;
            bitpos_next = bitpos_reg + POW_W'(win_rest);
            if (flush_reg != '0)
            begin
                flush_next = flush_reg - FLUSH_W'(1);
            end
        end

        if (do_skip)
        begin
            acc_next    = acc_reg >> tz_run;
            bitpos_next = bitpos_reg + POW_W'(tz_run);
        end

        if (do_digit)
        begin
            // Clearing the digit's bits subtracts its magnitude; a negative digit
            // carries the span into the bit above.
            acc_next = {acc_reg[ACC_W-1:DIG_W], acc_reg[DIG_W-1:0] & ~dinfo.clear_mask}
                       + (dinfo.neg ? ACC_W'(dinfo.span) : '0);
            digit_cnt_next = digit_cnt_reg + POW_W'(1);
        end

        if (do_end)
        begin
            digit_cnt_next = '0;
            last_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_bits_reg  <= WINDOW_BITS_RESET;
            acc_reg          <= '0;
            chunk_cnt_reg    <= '0;
            digit_cnt_reg    <= '0;
            bitpos_reg       <= '0;
            flush_reg        <= '0;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            chunk_cnt_reg <= chunk_cnt_next;
            digit_cnt_reg <= digit_cnt_next;
            bitpos_reg    <= bitpos_next;
            flush_reg     <= flush_next;
            last_reg      <= last_next;
            if (cfg_valid && cfg_ready)
            begin
                window_bits_reg <= cfg_data;
            end
            if (do_digit || do_end)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register, loaded only when the previous transaction is gone.
    always_ff @(posedge clk)
    begin
        if (do_digit)
        begin
            power_reg <= bitpos_reg;
            digit_reg <= dinfo.value;
            total_reg <= '0;
            end_reg   <= 1'b0;
        end
        else if (do_end)
        begin
            power_reg <= '0;
            digit_reg <= '0;
            total_reg <= digit_cnt_reg;
            end_reg   <= 1'b1;
        end
    end

    // An end transaction carries no digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_end |-> (power == '0) && (digit == '0))
        else $error("end transaction carries a digit");

    // Every digit transaction is odd and counts nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_end |-> digit[0] && (digit_total == '0))
        else $error("digit transaction is even or carries a total");

    // Flush windows are only pending for the last chunk of a scalar.
    assert property (@(posedge clk) disable iff (!rst_n)
        (flush_reg != '0) |-> last_reg)
        else $error("flush pending outside the last chunk");

    // A digit is only formed at a set bit, and it clears that bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        do_digit |-> acc_reg[0] ##1 !acc_reg[0])
        else $error("digit formed at a clear bit or left its bit set");

endmodule
